// ----- hw/rtl/cpfc_pkg.sv -----
package cpfc_pkg;

    localparam int TIME_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int WGT_BITS     = FRAC_BITS + 1;
    localparam int SPD_BITS     = 16;
    localparam int SPEED_BITS   = 2 * SPD_BITS;
    localparam int STEP_BITS    = 32;
    localparam int DIVN_BITS    = TIME_BITS + FRAC_BITS;
    localparam int MAG_BITS     = SPEED_BITS - 1 + STEP_BITS - 16;
    localparam int P_BITS       = 50;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = 32;

    localparam logic [WGT_BITS-1:0]      ONE_W = WGT_BITS'(1) << FRAC_BITS;
    localparam logic signed [P_BITS-1:0] ONE_P = P_BITS'(1) << FRAC_BITS;
    localparam logic [TIME_BITS-1:0]     INIT_DURATION = TIME_BITS'(1000000);
    localparam logic [SPD_BITS-1:0]      INIT_SPEED = SPD_BITS'(256);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FADE_IN   = 3'd0,
        CFG_FADE_OUT  = 3'd1,
        CFG_LOOP      = 3'd2,
        CFG_IMM_IN    = 3'd3,
        CFG_IMM_OUT   = 3'd4,
        CFG_SPEED     = 3'd5,
        CFG_INIT_DUR  = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        M_OFF = 3'd0,
        M_SUP = 3'd1,
        M_UP  = 3'd2,
        M_RUN = 3'd3,
        M_SDN = 3'd4,
        M_DN  = 3'd5,
        M_FIN = 3'd6
    } play_mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_STEP,
        S_MAG,
        S_POS,
        S_CHK,
        S_SWMUL,
        S_SWDIV,
        S_RDN,
        S_AREA,
        S_RDT,
        S_RAMP,
        S_RAMPDIV,
        S_FINAL,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_START,
        DP_STEP,
        DP_MAG,
        DP_POS,
        DP_SWMUL,
        DP_SWDIV,
        DP_RDN,
        DP_AREA,
        DP_RDT,
        DP_RAMP,
        DP_RAMPDIV,
        DP_FINAL,
        DP_EMIT
    } dp_op_t;

    typedef enum logic {
        AR_DIV,
        AR_MUL
    } arith_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   arith_req;
    } dp_cmd_t;

    typedef struct packed {
        logic early;
        logic sw;
        logic run;
        logic down_go;
        logic ramp_div;
        logic arith_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/cpfc_arith.sv -----
module cpfc_arith
    import cpfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req,
    input  arith_op_t             op,
    input  logic [DIVN_BITS-1:0]  opa,
    input  logic [TIME_BITS-1:0]  opb,
    output logic                  done,
    output logic [STEP_BITS-1:0]  result
);

    localparam int N  = DIVN_BITS;
    localparam int CW = $clog2(N);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    arith_op_t       op_reg;
    logic [N-1:0]    sh_reg;
    logic [TIME_BITS-1:0] b_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [N-1:0]    quo_reg;
    logic [N+1:0]    acc_reg;
    logic            sat_reg;
    logic [STEP_BITS-1:0] res_reg;

    logic                 start;
    logic                 last;
    logic                 sbit;
    logic [TIME_BITS:0]   trial;
    logic                 ge;
    logic [TIME_BITS-1:0] rem_step;
    logic [N-1:0]         quo_step;
    logic [N+1:0]         acc_sum;
    logic                 sat_step;
    logic [STEP_BITS-1:0] div_res;
    logic [STEP_BITS-1:0] mul_res;

    assign start = req && !busy_reg && !done_reg;
    assign last  = (cnt_reg == CW'(N - 1));
    assign sbit  = sh_reg[N-1];

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, sbit};
        ge       = (trial >= {1'b0, b_reg});
        rem_step = ge ? TIME_BITS'(trial - {1'b0, b_reg}) : trial[TIME_BITS-1:0];
        quo_step = {quo_reg[N-2:0], ge};
        div_res  = (quo_step[N-1:STEP_BITS] != '0) ? '1 : quo_step[STEP_BITS-1:0];
    end

    // MSB-first shift-add multiply with sticky saturation
    always_comb
    begin
        acc_sum  = {acc_reg[N:0], 1'b0} + (sbit ? (N+2)'(b_reg) : (N+2)'(0));
        sat_step = sat_reg || (acc_sum[N+1:N] != 2'b00);
        mul_res  = sat_step ? '1 : acc_sum[FRAC_BITS+STEP_BITS-1:FRAC_BITS];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= op;
            b_reg   <= opb;
            sh_reg  <= (op == AR_DIV) ? {opa[TIME_BITS-1:0], FRAC_BITS'(0)} : opa;
            rem_reg <= '0;
            quo_reg <= '0;
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[N-2:0], 1'b0};
            rem_reg <= rem_step;
            quo_reg <= quo_step;
            acc_reg <= acc_sum;
            sat_reg <= sat_step;
            if (last)
            begin
                res_reg <= (op_reg == AR_DIV) ? div_res : mul_res;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- hw/rtl/cpfc_datapath.sv -----
module cpfc_datapath
    import cpfc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [TIME_BITS-1:0]     time_delta,
    input  logic                     trigger_active,
    input  logic signed [SPD_BITS-1:0] speed_factor,
    input  logic [TIME_BITS-1:0]     queued_duration,
    input  logic                     cfg_write,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DAT_BITS-1:0]  cfg_data,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [2:0]               play_state,
    output logic [WGT_BITS-1:0]      blend_weight,
    output logic [WGT_BITS-1:0]      play_position,
    output logic                     switched_clip,
    output logic                     wrapped_at_start,
    output logic                     wrapped_at_end
);

    // configuration and persistent state
    logic [TIME_BITS-1:0] fade_in_reg, fade_in_next;
    logic [TIME_BITS-1:0] fade_out_reg, fade_out_next;
    logic                 loop_reg, loop_next;
    logic                 imin_reg, imin_next;
    logic                 imfo_reg, imfo_next;
    logic signed [SPD_BITS-1:0] base_speed_reg, base_speed_next;
    logic [TIME_BITS-1:0] active_dur_reg, active_dur_next;
    play_mode_t           mode_reg, mode_next;
    logic [WGT_BITS-1:0]  weight_reg, weight_next;
    logic [WGT_BITS-1:0]  position_reg, position_next;
    logic                 hold_reg, hold_next;
    logic                 out_valid_reg, out_valid_next;

    // per-tick working registers
    logic [TIME_BITS-1:0] td_reg, td_next;
    logic                 trig_reg, trig_next;
    logic signed [SPD_BITS-1:0] sf_reg, sf_next;
    logic [TIME_BITS-1:0] queued_reg, queued_next;
    logic signed [SPEED_BITS-1:0] speed_reg, speed_next;
    logic [TIME_BITS-1:0] dur_reg, dur_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [MAG_BITS-1:0]  mag_reg, mag_next;
    logic signed [P_BITS-1:0] p_reg, p_next;
    logic [STEP_BITS-1:0] dt_reg, dt_next;
    logic [STEP_BITS-1:0] rdn_reg, rdn_next;
    logic [STEP_BITS-1:0] tin_reg, tin_next;
    logic [STEP_BITS-1:0] rdt_reg, rdt_next;
    logic                 sw_reg, sw_next;
    logic                 ws_reg, ws_next;
    logic                 we_reg, we_next;
    play_mode_t           o_state_reg;
    logic [WGT_BITS-1:0]  o_weight_reg, o_pos_reg;
    logic                 o_sw_reg, o_ws_reg, o_we_reg;

    // arithmetic unit
    arith_op_t            ar_op;
    logic [DIVN_BITS-1:0] ar_a;
    logic [TIME_BITS-1:0] ar_b;
    logic                 ar_done;
    logic [STEP_BITS-1:0] ar_res;

    // decode signals
    play_mode_t           pre_mode;
    logic                 early, pos_clear, hold_set;
    logic                 ramp_up, ramp_dn, ramp_div;
    logic [SPEED_BITS-2:0] spd_abs;
    logic [SPEED_BITS-1:0] spd_neg;
    logic [SPEED_BITS-1+STEP_BITS-1:0] mag_prod;
    logic signed [P_BITS-1:0] pos_s, mag_s, sum, rdn_s, st_s, tend, tin, tin_min, pm1;
    logic                 area, down_go, sw_now;

    cpfc_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (cmd.arith_req),
        .op     (ar_op),
        .opa    (ar_a),
        .opb    (ar_b),
        .done   (ar_done),
        .result (ar_res)
    );

    // mode update at the head of a tick
    always_comb
    begin
        pre_mode  = mode_reg;
        early     = 1'b0;
        pos_clear = 1'b0;
        hold_set  = 1'b0;
        unique case (mode_reg)
            M_OFF:
            begin
                if (!trig_reg)
                begin
                    early = 1'b1;
                end
                else
                begin
                    pre_mode  = M_SUP;
                    pos_clear = 1'b1;
                end
            end
            M_SUP, M_UP:
            begin
                pre_mode = M_UP;
                if (weight_reg >= ONE_W)
                begin
                    hold_set = 1'b1;
                    pre_mode = M_RUN;
                end
            end
            M_SDN, M_DN:
            begin
                pre_mode = M_DN;
                if (weight_reg == '0)
                begin
                    pre_mode = M_FIN;
                end
                if (trig_reg && imin_reg && loop_reg)
                begin
                    pre_mode = M_SUP;
                end
            end
            M_FIN:
            begin
                if (trig_reg && imin_reg)
                begin
                    pre_mode = M_SUP;
                end
                else
                begin
                    pre_mode = M_OFF;
                    early    = 1'b1;
                end
            end
            default:
            begin
                pre_mode = mode_reg;
            end
        endcase
        if (pre_mode == M_RUN && !trig_reg && imfo_reg)
        begin
            pre_mode = M_SDN;
        end
    end

    always_comb
    begin
        spd_neg  = SPEED_BITS'(-speed_reg);
        spd_abs  = speed_reg[SPEED_BITS-1] ? spd_neg[SPEED_BITS-2:0]
                                           : speed_reg[SPEED_BITS-2:0];
        mag_prod = (SPEED_BITS+STEP_BITS-1)'(spd_abs) * (SPEED_BITS+STEP_BITS-1)'(step_reg);

        pos_s  = P_BITS'(position_reg);
        mag_s  = P_BITS'(mag_reg);
        sum    = speed_reg[SPEED_BITS-1] ? (pos_s - mag_s) : (pos_s + mag_s);
        sw_now = (sum > ONE_P) && (queued_reg != '0);

        rdn_s = P_BITS'(rdn_reg);
        st_s  = P_BITS'(step_reg);
        tend  = ONE_P - rdn_s;
        if (!speed_reg[SPEED_BITS-1])
        begin
            area = (p_reg > tend);
            tin  = p_reg - tend;
        end
        else
        begin
            area = (p_reg < rdn_s);
            tin  = rdn_s - p_reg;
        end
        tin_min = (st_s < tin) ? st_s : tin;
        down_go = !trig_reg && area && (!loop_reg || !hold_reg);

        ramp_up  = (mode_reg == M_SUP) || (mode_reg == M_UP);
        ramp_dn  = (mode_reg == M_SDN) || (mode_reg == M_DN);
        ramp_div = (ramp_up && weight_reg < ONE_W && fade_in_reg != '0)
                || (ramp_dn && weight_reg != '0 && fade_out_reg != '0);
        pm1      = p_reg - P_BITS'(1);
    end

    // operand selection for the shared unit
    always_comb
    begin
        ar_op = AR_DIV;
        ar_a  = DIVN_BITS'(td_reg);
        ar_b  = dur_reg;
        unique case (cmd.op)
            DP_SWMUL:
            begin
                ar_op = AR_MUL;
                ar_a  = p_reg[DIVN_BITS-1:0];
            end
            DP_SWDIV:   ar_a = DIVN_BITS'(dt_reg);
            DP_RDN:     ar_a = DIVN_BITS'(fade_out_reg);
            DP_RDT:
            begin
                ar_op = AR_MUL;
                ar_a  = DIVN_BITS'(tin_reg);
            end
            DP_RAMPDIV:
            begin
                ar_a = DIVN_BITS'(rdt_reg);
                ar_b = ramp_up ? fade_in_reg : fade_out_reg;
            end
            default:    ar_a = DIVN_BITS'(td_reg);
        endcase
    end

    always_comb
    begin
        fade_in_next    = fade_in_reg;
        fade_out_next   = fade_out_reg;
        loop_next       = loop_reg;
        imin_next       = imin_reg;
        imfo_next       = imfo_reg;
        base_speed_next = base_speed_reg;
        active_dur_next = active_dur_reg;
        mode_next       = mode_reg;
        weight_next     = weight_reg;
        position_next   = position_reg;
        hold_next       = hold_reg;
        td_next         = td_reg;
        trig_next       = trig_reg;
        sf_next         = sf_reg;
        queued_next     = queued_reg;
        speed_next      = speed_reg;
        dur_next        = dur_reg;
        step_next       = step_reg;
        mag_next        = mag_reg;
        p_next          = p_reg;
        dt_next         = dt_reg;
        rdn_next        = rdn_reg;
        tin_next        = tin_reg;
        rdt_next        = rdt_reg;
        sw_next         = sw_reg;
        ws_next         = ws_reg;
        we_next         = we_reg;
        out_valid_next  = out_valid_reg && out_stall;

        unique case (cmd.op)
            DP_ACCEPT:
            begin
                td_next     = time_delta;
                trig_next   = trigger_active;
                sf_next     = speed_factor;
                queued_next = queued_duration;
            end
            DP_START:
            begin
                speed_next = base_speed_reg * sf_reg;
                dur_next   = (active_dur_reg == '0) ? TIME_BITS'(1) : active_dur_reg;
                rdt_next   = td_reg;
                sw_next    = 1'b0;
                ws_next    = 1'b0;
                we_next    = 1'b0;
                mode_next  = pre_mode;
                if (hold_set)
                begin
                    hold_next = 1'b1;
                end
                if (pos_clear)
                begin
                    position_next = '0;
                end
            end
            DP_STEP:
            begin
                if (ar_done)
                begin
                    step_next = ar_res;
                end
            end
            DP_MAG:
            begin
                mag_next = mag_prod[SPEED_BITS+STEP_BITS-2:16];
            end
            DP_POS:
            begin
                p_next  = sw_now ? (sum - ONE_P) : sum;
                sw_next = sw_now;
            end
            DP_SWMUL:
            begin
                if (ar_done)
                begin
                    dt_next         = ar_res;
                    active_dur_next = queued_reg;
                    dur_next        = queued_reg;
                end
            end
            DP_SWDIV:
            begin
                if (ar_done)
                begin
                    step_next = ar_res;
                end
            end
            DP_RDN:
            begin
                if (ar_done)
                begin
                    rdn_next = ar_res;
                end
            end
            DP_AREA:
            begin
                hold_next = area;
                if (down_go)
                begin
                    mode_next = M_SDN;
                    tin_next  = tin_min[STEP_BITS-1:0];
                end
            end
            DP_RDT:
            begin
                if (ar_done)
                begin
                    rdt_next = ar_res;
                end
            end
            DP_RAMP:
            begin
                if (ramp_up && weight_reg < ONE_W && fade_in_reg == '0)
                begin
                    weight_next = ONE_W;
                end
                else if (ramp_dn && weight_reg != '0 && fade_out_reg == '0)
                begin
                    weight_next = '0;
                end
            end
            DP_RAMPDIV:
            begin
                if (ar_done)
                begin
                    if (ramp_up)
                    begin
                        weight_next = (ar_res >= STEP_BITS'(ONE_W - weight_reg))
                                    ? ONE_W : (weight_reg + ar_res[WGT_BITS-1:0]);
                    end
                    else
                    begin
                        weight_next = (ar_res >= STEP_BITS'(weight_reg))
                                    ? '0 : (weight_reg - ar_res[WGT_BITS-1:0]);
                    end
                end
            end
            DP_FINAL:
            begin
                if (loop_reg)
                begin
                    if (p_reg > ONE_P)
                    begin
                        position_next = {1'b0, pm1[FRAC_BITS-1:0]} + WGT_BITS'(1);
                        hold_next     = 1'b0;
                        we_next       = 1'b1;
                    end
                    else if (p_reg < 0)
                    begin
                        position_next = {1'b0, p_reg[FRAC_BITS-1:0]};
                        hold_next     = 1'b0;
                        ws_next       = 1'b1;
                    end
                    else
                    begin
                        position_next = p_reg[WGT_BITS-1:0];
                    end
                end
                else
                begin
                    if (p_reg > ONE_P)
                    begin
                        position_next = ONE_W;
                    end
                    else if (p_reg < 0)
                    begin
                        position_next = '0;
                    end
                    else
                    begin
                        position_next = p_reg[WGT_BITS-1:0];
                    end
                end
            end
            DP_EMIT:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase

        if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FADE_IN:  fade_in_next    = cfg_data[TIME_BITS-1:0];
                CFG_FADE_OUT: fade_out_next   = cfg_data[TIME_BITS-1:0];
                CFG_LOOP:     loop_next       = cfg_data[0];
                CFG_IMM_IN:   imin_next       = cfg_data[0];
                CFG_IMM_OUT:  imfo_next       = cfg_data[0];
                CFG_SPEED:    base_speed_next = cfg_data[SPD_BITS-1:0];
                CFG_INIT_DUR: active_dur_next = cfg_data[TIME_BITS-1:0];
                default:      loop_next       = loop_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_in_reg    <= '0;
            fade_out_reg   <= '0;
            loop_reg       <= 1'b0;
            imin_reg       <= 1'b0;
            imfo_reg       <= 1'b0;
            base_speed_reg <= INIT_SPEED;
            active_dur_reg <= INIT_DURATION;
            mode_reg       <= M_OFF;
            weight_reg     <= '0;
            position_reg   <= '0;
            hold_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fade_in_reg    <= fade_in_next;
            fade_out_reg   <= fade_out_next;
            loop_reg       <= loop_next;
            imin_reg       <= imin_next;
            imfo_reg       <= imfo_next;
            base_speed_reg <= base_speed_next;
            active_dur_reg <= active_dur_next;
            mode_reg       <= mode_next;
            weight_reg     <= weight_next;
            position_reg   <= position_next;
            hold_reg       <= hold_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        td_reg     <= td_next;
        trig_reg   <= trig_next;
        sf_reg     <= sf_next;
        queued_reg <= queued_next;
        speed_reg  <= speed_next;
        dur_reg    <= dur_next;
        step_reg   <= step_next;
        mag_reg    <= mag_next;
        p_reg      <= p_next;
        dt_reg     <= dt_next;
        rdn_reg    <= rdn_next;
        tin_reg    <= tin_next;
        rdt_reg    <= rdt_next;
        sw_reg     <= sw_next;
        ws_reg     <= ws_next;
        we_reg     <= we_next;
        if (cmd.op == DP_EMIT)
        begin
            o_state_reg  <= mode_reg;
            o_weight_reg <= weight_reg;
            o_pos_reg    <= position_reg;
            o_sw_reg     <= sw_reg;
            o_ws_reg     <= ws_reg;
            o_we_reg     <= we_reg;
        end
    end

    always_comb
    begin
        status.early      = early;
        status.sw         = sw_reg;
        status.run        = (mode_reg == M_RUN);
        status.down_go    = down_go;
        status.ramp_div   = ramp_div;
        status.arith_done = ar_done;
        status.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid        = out_valid_reg;
    assign play_state       = o_state_reg;
    assign blend_weight     = o_weight_reg;
    assign play_position    = o_pos_reg;
    assign switched_clip    = o_sw_reg;
    assign wrapped_at_start = o_ws_reg;
    assign wrapped_at_end   = o_we_reg;

endmodule

// ----- hw/rtl/cpfc_ctrl.sv -----
module cpfc_ctrl
    import cpfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = DP_NONE;
        cmd.arith_req = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_ACCEPT;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.op     = DP_START;
                state_next = status.early ? S_EMIT : S_STEP;
            end
            S_STEP:
            begin
                cmd.op        = DP_STEP;
                cmd.arith_req = 1'b1;
                if (status.arith_done)
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                cmd.op     = DP_MAG;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.op     = DP_POS;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (status.sw)
                    state_next = S_SWMUL;
                else if (status.run)
                    state_next = S_RDN;
                else
                    state_next = S_RAMP;
            end
            S_SWMUL:
            begin
                cmd.op        = DP_SWMUL;
                cmd.arith_req = 1'b1;
                if (status.arith_done)
                begin
                    state_next = S_SWDIV;
                end
            end
            S_SWDIV:
            begin
                cmd.op        = DP_SWDIV;
                cmd.arith_req = 1'b1;
                if (status.arith_done)
                begin
                    state_next = status.run ? S_RDN : S_RAMP;
                end
            end
            S_RDN:
            begin
                cmd.op        = DP_RDN;
                cmd.arith_req = 1'b1;
                if (status.arith_done)
                begin
                    state_next = S_AREA;
                end
            end
            S_AREA:
            begin
                cmd.op     = DP_AREA;
                state_next = status.down_go ? S_RDT : S_RAMP;
            end
            S_RDT:
            begin
                cmd.op        = DP_RDT;
                cmd.arith_req = 1'b1;
                if (status.arith_done)
                begin
                    state_next = S_RAMP;
                end
            end
            S_RAMP:
            begin
                cmd.op     = DP_RAMP;
                state_next = status.ramp_div ? S_RAMPDIV : S_FINAL;
            end
            S_RAMPDIV:
            begin
                cmd.op        = DP_RAMPDIV;
                cmd.arith_req = 1'b1;
                if (status.arith_done)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                cmd.op     = DP_FINAL;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ----- hw/rtl/clip_playback_fade_controller.sv -----
// A tick that stays off or ends off goes from the mode update straight to the result; any
// other tick runs the step divide, plus a multiply and a divide for a clip switch, a divide
// for the ramp-down boundary check while running, a multiply when the boundary is crossed
// and a divide for a weight ramp. A new tick is taken only once the last result is loaded,
// in the cycle after; the shared 48-step serial divide/multiply unit does each operation.
// Reset (rst_n, async low): off, zero weight and position, duration 1000000 us, speed 1.0.
module clip_playback_fade_controller
    import cpfc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // tick input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [TIME_BITS-1:0]       time_delta,
    input  logic                       trigger_active,
    input  logic signed [SPD_BITS-1:0] speed_factor,
    input  logic [TIME_BITS-1:0]       queued_duration,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 play_state,
    output logic [WGT_BITS-1:0]        blend_weight,
    output logic [WGT_BITS-1:0]        play_position,
    output logic                       switched_clip,
    output logic                       wrapped_at_start,
    output logic                       wrapped_at_end,
    // register write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_DAT_BITS-1:0]    cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Register writes are always taken; software writes only while idle.
    assign cfg_ready = 1'b1;

    // Sequencer: steps one tick through mode update, position advance,
    // clip switch, ramp-down boundary, weight ramp and wrap/clamp.
    cpfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: holds registers and state, owns the serial arithmetic unit
    // and the output register that parts the result side from the input side.
    cpfc_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .time_delta       (time_delta),
        .trigger_active   (trigger_active),
        .speed_factor     (speed_factor),
        .queued_duration  (queued_duration),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .play_state       (play_state),
        .blend_weight     (blend_weight),
        .play_position    (play_position),
        .switched_clip    (switched_clip),
        .wrapped_at_start (wrapped_at_start),
        .wrapped_at_end   (wrapped_at_end)
    );

endmodule

// ----- hw/rtl/cpfc_checker.sv -----
module cpfc_assertions
    import cpfc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [TIME_BITS-1:0]       time_delta,
    input  logic                       trigger_active,
    input  logic signed [SPD_BITS-1:0] speed_factor,
    input  logic [TIME_BITS-1:0]       queued_duration,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [2:0]                 play_state,
    input  logic [WGT_BITS-1:0]        blend_weight,
    input  logic [WGT_BITS-1:0]        play_position,
    input  logic                       switched_clip,
    input  logic                       wrapped_at_start,
    input  logic                       wrapped_at_end,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_DAT_BITS-1:0]    cfg_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(blend_weight)
            && $stable(play_position) && $stable(play_state))
        else $error("stalled result changed");

    // weight and position stay within [0, 1.0]
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> blend_weight <= ONE_W && play_position <= ONE_W)
        else $error("weight or position out of range");

    // a wrap goes one way only
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(wrapped_at_start && wrapped_at_end))
        else $error("wrapped at both ends");

    // an off result carries no event flags
    a_off_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && play_state == M_OFF |->
            !switched_clip && !wrapped_at_start && !wrapped_at_end)
        else $error("event flag in off state");

    // an accepted tick is not followed by another in the next cycle
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("tick accepted while busy");

endmodule

bind clip_playback_fade_controller cpfc_assertions u_cpfc_checker (.*);
